// File: design/assert_macros.svh
// Assertion macros shared by the rank counter modules.
// Each macro takes a label, the clock, the active-low reset and the property terms.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SSRC_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define SSRC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: design/ssrc_pkg.sv
// Shared types and constants of the sorted-set rank counter.
// Used by the front, queue, back and top level; depends on nothing.
`default_nettype none

package ssrc_pkg;

    localparam int CAPACITY   = 1024;
    localparam int VALUE_BITS = 16;
    localparam int ADDR_W     = $clog2(CAPACITY);
    localparam int CNT_W      = $clog2(CAPACITY + 1);

    // field widths of the streams
    localparam int CMD_W     = 2;
    localparam int VALUE_W   = 16;
    localparam int COUNT_W   = 11;
    localparam int TOTAL_W   = 48;
    localparam int TDATA_OUT_W = ((3 * COUNT_W + 3 * TOTAL_W + 7) / 8) * 8;

    // command queue between front and back
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    // command codes on the input stream
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_QUERY  = 2'd1,
        OP_CLEAR  = 2'd2
    } op_t;

    typedef struct packed {
        op_t                   op;
        logic [VALUE_BITS-1:0] value;
    } item_t;

    typedef struct packed {
        logic [COUNT_W-1:0] greater_count;
        logic [COUNT_W-1:0] less_count;
        logic [COUNT_W-1:0] equal_count;
        logic [TOTAL_W-1:0] total_greater;
        logic [TOTAL_W-1:0] total_less;
        logic [TOTAL_W-1:0] total_equal;
    } result_t;

endpackage

`default_nettype wire

// File: design/ssrc_front.sv
// Front end: takes input transfers, decodes the command and drops unused codes.
// Depends on ssrc_pkg; feeds ssrc_fifo.
`default_nettype none

module ssrc_front (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    input  wire logic [ssrc_pkg::CMD_W-1:0]   s_cmd,
    input  wire logic [ssrc_pkg::VALUE_W-1:0] s_value,
    input  wire logic                         q_full,
    output logic                              q_push,
    output ssrc_pkg::item_t                   q_item
);

    logic            hold_valid_reg, hold_valid_next;
    ssrc_pkg::item_t hold_item_reg,  hold_item_next;
    logic            cmd_ok;
    logic            accept;
    ssrc_pkg::op_t   op_dec;

    // decode the command; code 3 has no effect and is dropped here
    always_comb begin
        cmd_ok = 1'b1;
        op_dec = ssrc_pkg::OP_INSERT;
        case (s_cmd)
            ssrc_pkg::CMD_INSERT: op_dec = ssrc_pkg::OP_INSERT;
            ssrc_pkg::CMD_QUERY:  op_dec = ssrc_pkg::OP_QUERY;
            ssrc_pkg::CMD_CLEAR:  op_dec = ssrc_pkg::OP_CLEAR;
            default:              cmd_ok = 1'b0;
        endcase
    end

    assign q_push   = hold_valid_reg && !q_full;
    assign s_tready = !hold_valid_reg || !q_full;
    assign accept   = s_tvalid && s_tready;
    assign q_item   = hold_item_reg;

    // one-entry holding stage
    always_comb begin
        hold_valid_next = hold_valid_reg && !q_push;
        hold_item_next  = hold_item_reg;
        if (accept && cmd_ok) begin
            hold_valid_next     = 1'b1;
            hold_item_next.op    = op_dec;
            hold_item_next.value = s_value[ssrc_pkg::VALUE_BITS-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_valid_reg <= 1'b0;
        end else begin
            hold_valid_reg <= hold_valid_next;
        end
        hold_item_reg <= hold_item_next;
    end

endmodule

`default_nettype wire

// File: design/ssrc_fifo.sv
// Short command queue that decouples the front end from the search engine.
// Depends on ssrc_pkg.
`default_nettype none

`include "assert_macros.svh"

module ssrc_fifo (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      push,
    input  wire ssrc_pkg::item_t push_item,
    output logic           full,
    output logic           pop_valid,
    output ssrc_pkg::item_t pop_item,
    input  wire logic      pop
);

    localparam int CW = $clog2(ssrc_pkg::FIFO_DEPTH + 1);

    ssrc_pkg::item_t                entry_reg [ssrc_pkg::FIFO_DEPTH];
    logic [ssrc_pkg::FIFO_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [ssrc_pkg::FIFO_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]                  fill_reg,   fill_next;

    assign full      = (fill_reg == CW'(ssrc_pkg::FIFO_DEPTH));
    assign pop_valid = (fill_reg != '0);
    assign pop_item  = entry_reg[rd_ptr_reg];

    // pointer and fill bookkeeping
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push) begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            fill_next = fill_reg + 1'b1;
        end else if (pop && !push) begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    `SSRC_ASSERT_IMPL(a_fill_bound, aclk, aresetn, 1'b1, fill_reg <= CW'(ssrc_pkg::FIFO_DEPTH))
    `SSRC_ASSERT_IMPL(a_no_pop_empty, aclk, aresetn, pop, fill_reg != '0)

endmodule

`default_nettype wire

// File: design/ssrc_back.sv
// Back end: sorted store, binary search sequencer, insert shifter and totals.
// Depends on ssrc_pkg; takes commands from ssrc_fifo.
`default_nettype none

`include "assert_macros.svh"

module ssrc_back (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       q_valid,
    input  wire ssrc_pkg::item_t q_item,
    output logic            q_pop,
    output logic            m_valid,
    input  wire logic       m_ready,
    output ssrc_pkg::result_t m_result
);

    localparam int CNT_W   = ssrc_pkg::CNT_W;
    localparam int ADDR_W  = ssrc_pkg::ADDR_W;
    localparam int VB      = ssrc_pkg::VALUE_BITS;
    localparam int TOTAL_W = ssrc_pkg::TOTAL_W;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_PROBE  = 6'b000010,
        ST_CMP    = 6'b000100,
        ST_SHRD   = 6'b001000,
        ST_SHWR   = 6'b010000,
        ST_RESULT = 6'b100000
    } state_t;

    // sorted store, one write and one registered read per cycle
    logic [VB-1:0]     mem [ssrc_pkg::CAPACITY];
    logic [VB-1:0]     rd_data_reg;
    logic [ADDR_W-1:0] rd_addr;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_wa;
    logic [VB-1:0]     mem_wd;

    state_t            state_reg,  state_next;
    ssrc_pkg::item_t   item_reg,   item_next;
    logic [CNT_W-1:0]  cnt_reg,    cnt_next;
    logic [CNT_W-1:0]  lo_reg,     lo_next;
    logic [CNT_W-1:0]  hi_reg,     hi_next;
    logic [CNT_W-1:0]  upper_reg,  upper_next;
    logic [CNT_W-1:0]  idx_reg,    idx_next;
    logic              or_eq_reg,  or_eq_next;
    logic [TOTAL_W-1:0] tg_reg, tg_next, tl_reg, tl_next, te_reg, te_next;
    logic              m_valid_reg, m_valid_next;
    ssrc_pkg::result_t res_reg,    res_next;

    logic [CNT_W-1:0]  mid;
    logic [CNT_W-1:0]  idx_dec;
    logic              go_right;
    logic              out_free;
    logic [CNT_W-1:0]  greater, less, equal;

    function automatic logic [TOTAL_W-1:0] sat_add(input logic [TOTAL_W-1:0] total,
                                                   input logic [CNT_W-1:0] inc);
        logic [TOTAL_W:0] s;
        s = {1'b0, total} + (TOTAL_W + 1)'(inc);
        return s[TOTAL_W] ? {TOTAL_W{1'b1}} : s[TOTAL_W-1:0];
    endfunction

    assign mid      = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign idx_dec  = idx_reg - 1'b1;
    assign go_right = or_eq_reg ? (rd_data_reg < item_reg.value)
                                : (rd_data_reg <= item_reg.value);
    assign out_free = !m_valid_reg || m_ready;
    assign greater  = cnt_reg - upper_reg;
    assign less     = lo_reg;
    assign equal    = upper_reg - lo_reg;
    assign q_pop    = (state_reg == ST_IDLE) && q_valid;
    assign m_valid  = m_valid_reg;
    assign m_result = res_reg;

    // sequencer
    always_comb begin
        state_next   = state_reg;
        item_next    = item_reg;
        cnt_next     = cnt_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        upper_next   = upper_reg;
        idx_next     = idx_reg;
        or_eq_next   = or_eq_reg;
        tg_next      = tg_reg;
        tl_next      = tl_reg;
        te_next      = te_reg;
        res_next     = res_reg;
        m_valid_next = m_valid_reg && !m_ready;
        rd_addr      = mid[ADDR_W-1:0];
        mem_we       = 1'b0;
        mem_wa       = lo_reg[ADDR_W-1:0];
        mem_wd       = item_reg.value;
        case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    item_next  = q_item;
                    lo_next    = '0;
                    hi_next    = cnt_reg;
                    or_eq_next = 1'b0;
                    case (q_item.op)
                        ssrc_pkg::OP_INSERT: begin
                            if (cnt_reg != CNT_W'(ssrc_pkg::CAPACITY)) begin
                                state_next = ST_PROBE;
                            end
                        end
                        ssrc_pkg::OP_QUERY: state_next = ST_PROBE;
                        ssrc_pkg::OP_CLEAR: begin
                            cnt_next = '0;
                            tg_next  = '0;
                            tl_next  = '0;
                            te_next  = '0;
                        end
                        default: ;
                    endcase
                end
            end
            // one probe: issue the read at mid, or finish this search
            ST_PROBE: begin
                if (lo_reg < hi_reg) begin
                    state_next = ST_CMP;
                end else if (item_reg.op == ssrc_pkg::OP_INSERT) begin
                    idx_next   = cnt_reg;
                    state_next = ST_SHRD;
                end else if (!or_eq_reg) begin
                    upper_next = lo_reg;
                    lo_next    = '0;
                    hi_next    = cnt_reg;
                    or_eq_next = 1'b1;
                end else begin
                    state_next = ST_RESULT;
                end
            end
            ST_CMP: begin
                if (go_right) begin
                    lo_next = mid + 1'b1;
                end else begin
                    hi_next = mid;
                end
                state_next = ST_PROBE;
            end
            // move entries above the insert point up by one, top first
            ST_SHRD: begin
                if (idx_reg > lo_reg) begin
                    rd_addr    = idx_dec[ADDR_W-1:0];
                    state_next = ST_SHWR;
                end else begin
                    mem_we     = 1'b1;
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_SHWR: begin
                mem_we     = 1'b1;
                mem_wa     = idx_reg[ADDR_W-1:0];
                mem_wd     = rd_data_reg;
                idx_next   = idx_dec;
                state_next = ST_SHRD;
            end
            // counts and totals into the output register
            ST_RESULT: begin
                if (out_free) begin
                    tg_next = sat_add(tg_reg, greater);
                    tl_next = sat_add(tl_reg, less);
                    te_next = sat_add(te_reg, equal);
                    res_next.greater_count = ssrc_pkg::COUNT_W'(greater);
                    res_next.less_count    = ssrc_pkg::COUNT_W'(less);
                    res_next.equal_count   = ssrc_pkg::COUNT_W'(equal);
                    res_next.total_greater = tg_next;
                    res_next.total_less    = tl_next;
                    res_next.total_equal   = te_next;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            tg_reg      <= '0;
            tl_reg      <= '0;
            te_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            tg_reg      <= tg_next;
            tl_reg      <= tl_next;
            te_reg      <= te_next;
            m_valid_reg <= m_valid_next;
        end
        item_reg  <= item_next;
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        upper_reg <= upper_next;
        idx_reg   <= idx_next;
        or_eq_reg <= or_eq_next;
        res_reg   <= res_next;
    end

    // store access
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        rd_data_reg <= mem[rd_addr];
    end

    `SSRC_ASSERT_IMPL(a_cnt_bound, aclk, aresetn, 1'b1, cnt_reg <= CNT_W'(ssrc_pkg::CAPACITY))
    `SSRC_ASSERT_IMPL(a_window, aclk, aresetn, (state_reg == ST_CMP), (lo_reg < hi_reg) && (hi_reg <= cnt_reg))
    `SSRC_ASSERT_IMPL(a_shift_range, aclk, aresetn, (state_reg == ST_SHWR), (idx_reg > lo_reg) && (idx_reg <= cnt_reg))
    `SSRC_ASSERT_NEXT(a_result_load, aclk, aresetn, (state_reg == ST_RESULT) && out_free, m_valid_reg && (state_reg == ST_IDLE))

endmodule

`default_nettype wire

// File: design/sorted_set_rank_counter.sv
// Sorted-set rank counter. Insert (cmd 0) places a value in a sorted store of up to 1024
// entries after any equal ones, and is ignored when the store is full; query (cmd 1) returns
// the counts of stored values greater, less and equal to the value with saturating running
// totals; clear (cmd 2) empties the store and zeroes the totals; cmd 3 is dropped. Each
// search probe in the back end is a read of the store at mid, then a compare, so a query
// runs two binary searches over the n stored values, an insert one search and then a move
// up of each entry above the insert point, and a clear needs no search. A four-entry
// command queue lets input transfers continue while the back end works, and the result
// register holds one answer while the next command runs.
// Depends on ssrc_pkg, ssrc_front, ssrc_fifo and ssrc_back.
`default_nettype none

module sorted_set_rank_counter (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,   // [15:0] value
    input  wire logic [1:0]  s_axis_tuser,   // [1:0] cmd
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [10:0] greater_count, [21:11] less_count, [32:22] equal_count,
    // [80:33] total_greater, [128:81] total_less, [176:129] total_equal, rest zero
    output logic [ssrc_pkg::TDATA_OUT_W-1:0] m_axis_tdata
);

    localparam int PAD_W = ssrc_pkg::TDATA_OUT_W - 3 * ssrc_pkg::COUNT_W
                           - 3 * ssrc_pkg::TOTAL_W;

    logic              q_push, q_full, q_valid, q_pop;
    ssrc_pkg::item_t   push_item, pop_item;
    ssrc_pkg::result_t result;

    ssrc_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_axis_tvalid),
        .s_tready (s_axis_tready),
        .s_cmd    (s_axis_tuser),
        .s_value  (s_axis_tdata),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_item   (push_item)
    );

    ssrc_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (push_item),
        .full      (q_full),
        .pop_valid (q_valid),
        .pop_item  (pop_item),
        .pop       (q_pop)
    );

    ssrc_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_item   (pop_item),
        .q_pop    (q_pop),
        .m_valid  (m_axis_tvalid),
        .m_ready  (m_axis_tready),
        .m_result (result)
    );

    // pack result fields, first field in the low bits
    assign m_axis_tdata = {{PAD_W{1'b0}},
                           result.total_equal,
                           result.total_less,
                           result.total_greater,
                           result.equal_count,
                           result.less_count,
                           result.greater_count};

endmodule

`default_nettype wire
